[hdl/tds_pkg.sv]
package tds_pkg;

   localparam int TASKS = 16;
   localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int TIME_W = 32;
   localparam int STAG_W = 24;
   localparam logic [STAG_W-1:0] STAGGER_STEP = 24'd223500;

   typedef enum logic [1:0] {
      REQ_ADD_ONCE   = 2'd0,
      REQ_ADD_REPEAT = 2'd1,
      REQ_REMOVE     = 2'd2,
      REQ_TICK       = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD,
      S_EVAL,
      S_DIV,
      S_FIX,
      S_HIT,
      S_END
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_clear;
      logic scan_inc;
      logic rd_en;
      logic add_wr;
      logic remove_wr;
      logic tick_clear;
      logic div_start;
      logic fix_wr;
      logic load_hit;
      logic load_end;
   } cmd_type;

   typedef struct packed {
      logic req_tick;
      logic req_remove;
      logic idx_ok;
      logic slot_due;
      logic slot_periodic;
      logic slot_behind;
      logic scan_last;
      logic div_done;
   } status_type;

endpackage

[hdl/tds_rem.sv]
module tds_rem
   import tds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic [TIME_W-1:0] remainder,
   output logic              done
);

   localparam int CNT_W = $clog2(TIME_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [TIME_W-1:0] dsr_ff, dsr_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W:0]   shifted;
   logic [TIME_W:0]   trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted  = {rem_ff, dvd_ff[TIME_W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         dsr_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         if (!trial[TIME_W]) begin
            rem_in = trial[TIME_W-1:0];
         end else begin
            rem_in = shifted[TIME_W-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

[hdl/tds_datapath.sv]
module tds_datapath
   import tds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_type,
   input  logic [3:0]        req_task_index,
   input  logic [TIME_W-1:0] req_amount,
   input  logic [TIME_W-1:0] req_now,
   input  logic              req_startup_add,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_fired,
   output logic [3:0]        rsp_fired_task,
   output logic              rsp_periodic,
   output logic              rsp_last
);

   req_code_type      type_ff;
   logic [3:0]        idx_ff;
   logic [TIME_W-1:0] amount_ff;
   logic [TIME_W-1:0] now_ff;
   logic              startup_ff;

   logic [TIME_W-1:0] due_mem [TASKS];
   logic [TIME_W-1:0] per_mem [TASKS];
   logic [TASKS-1:0]  valid_ff;

   logic [TIME_W-1:0] due_rd_ff;
   logic [TIME_W-1:0] per_rd_ff;
   logic              vld_rd_ff;

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [STAG_W-1:0] stag_ff, stag_in;

   logic              fired_ff, periodic_ff, last_ff;
   logic [3:0]        task_ff;

   logic [IDX_W-1:0]  addr;
   logic [TIME_W-1:0] due_eff, per_eff, delta;
   logic [TIME_W-1:0] nt_sum, nt_bump, nt;
   logic              per_big;
   logic [TIME_W-1:0] dvd, dsr, rem, dist_new, due_fix;
   logic              rem_done;

   tds_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .remainder (rem),
      .done      (rem_done)
   );

   assign addr    = (type_ff == REQ_TICK) ? scan_ff : IDX_W'(idx_ff);
   assign due_eff = vld_rd_ff ? due_rd_ff : '0;
   assign per_eff = vld_rd_ff ? per_rd_ff : '0;
   assign delta   = due_eff - now_ff;
   assign per_big = per_eff[TIME_W-1];

   // catch-up: only the remainder of the step count is needed
   always_comb begin
      if (!per_big) begin
         dvd = '0 - delta;
         dsr = per_eff;
         dist_new = (rem == '0) ? '0 : per_eff - rem;
      end else begin
         dvd = {1'b0, delta[TIME_W-2:0]};
         dsr = '0 - per_eff;
         dist_new = {1'b1, {(TIME_W-1){1'b0}}} + rem + per_eff;
      end
      due_fix = now_ff + dist_new;
   end

   always_comb begin
      nt_sum  = now_ff + amount_ff + {{(TIME_W-STAG_W){1'b0}}, stag_ff & {STAG_W{startup_ff}}};
      nt_bump = (nt_sum == due_eff) ? nt_sum + 1'b1 : nt_sum;
      nt      = (nt_bump == '0) ? TIME_W'(1) : nt_bump;
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + 1'b1;
      end
      stag_in = stag_ff;
      if (cmd.add_wr && startup_ff) begin
         stag_in = stag_ff + STAGGER_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff    <= req_code_type'(req_type);
         idx_ff     <= req_task_index;
         amount_ff  <= req_amount;
         now_ff     <= req_now;
         startup_ff <= req_startup_add;
      end
      if (cmd.rd_en) begin
         due_rd_ff <= due_mem[addr];
         per_rd_ff <= per_mem[addr];
         vld_rd_ff <= valid_ff[addr];
      end
      if (cmd.add_wr) begin
         due_mem[addr] <= nt;
         per_mem[addr] <= (type_ff == REQ_ADD_REPEAT) ? amount_ff : '0;
      end else if (cmd.fix_wr) begin
         due_mem[addr] <= due_fix;
      end
      scan_ff <= scan_in;
      if (cmd.load_hit) begin
         fired_ff    <= 1'b1;
         task_ff     <= 4'(scan_ff);
         periodic_ff <= per_eff != '0;
         last_ff     <= 1'b0;
      end else if (cmd.load_end) begin
         fired_ff    <= 1'b0;
         task_ff     <= '0;
         periodic_ff <= 1'b0;
         last_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         stag_ff  <= '0;
      end else begin
         stag_ff <= stag_in;
         if (cmd.add_wr) begin
            valid_ff[addr] <= 1'b1;
         end else if (cmd.remove_wr || cmd.tick_clear) begin
            valid_ff[addr] <= 1'b0;
         end
      end
   end

   always_comb begin
      status.req_tick      = type_ff == REQ_TICK;
      status.req_remove    = type_ff == REQ_REMOVE;
      status.idx_ok        = 32'(idx_ff) < 32'(TASKS);
      status.slot_due      = (due_eff != '0) && (delta[TIME_W-1] || delta == '0);
      status.slot_periodic = per_eff != '0;
      status.slot_behind   = delta[TIME_W-1];
      status.scan_last     = scan_ff == IDX_W'(TASKS - 1);
      status.div_done      = rem_done;
   end

   assign rsp_fired      = fired_ff;
   assign rsp_fired_task = task_ff;
   assign rsp_periodic   = periodic_ff;
   assign rsp_last       = last_ff;

endmodule

[hdl/tds_ctrl.sv]
module tds_ctrl
   import tds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (status.req_tick) begin
               state_in = S_RD;
            end else if (!status.idx_ok || status.req_remove) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            if (!status.req_tick) begin
               state_in = S_IDLE;
            end else if (status.slot_due) begin
               if (status.slot_periodic && status.slot_behind) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_HIT;
               end
            end else if (status.scan_last) begin
               state_in = S_END;
            end else begin
               state_in = S_RD;
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_FIX;
         end
         S_FIX: state_in = S_HIT;
         S_HIT: begin
            if (!rsp_stall) begin
               state_in = status.scan_last ? S_END : S_RD;
            end
         end
         S_END: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = state_ff != S_IDLE;
      rsp_valid = (state_ff == S_HIT) || (state_ff == S_END);
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.scan_clear = status.req_tick;
            cmd.remove_wr  = !status.req_tick && status.idx_ok && status.req_remove;
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_EVAL: begin
            if (!status.req_tick) begin
               cmd.add_wr = 1'b1;
            end else if (status.slot_due) begin
               if (!status.slot_periodic) begin
                  cmd.tick_clear = 1'b1;
                  cmd.load_hit   = 1'b1;
               end else if (status.slot_behind) begin
                  cmd.div_start = 1'b1;
               end else begin
                  cmd.load_hit = 1'b1;
               end
            end else if (status.scan_last) begin
               cmd.load_end = 1'b1;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_FIX: begin
            cmd.fix_wr   = 1'b1;
            cmd.load_hit = 1'b1;
         end
         S_HIT: begin
            if (!rsp_stall) begin
               cmd.load_end = status.scan_last;
               cmd.scan_inc = !status.scan_last;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/task_deadline_scheduler.sv]
// Deadline table of TASKS slots, one request word at a time. An add passes
// through decode, table read and evaluate before the next request is taken, a
// remove through decode only, and neither gives a result word. A tick walks the
// slots from index 0, each with a table read, then a compare, plus a result
// word per reported task that is held while rsp_stall is high; a periodic task
// that is behind also waits for the bit-serial remainder unit that computes its
// catch-up in closed form. The final word of a tick has rsp_last set. A new
// request is taken only after the previous one has finished, including its
// last word.
module task_deadline_scheduler
   import tds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [3:0]        req_task_index,
   input  logic [TIME_W-1:0] req_amount,
   input  logic [TIME_W-1:0] req_now,
   input  logic              req_startup_add,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_fired,
   output logic [3:0]        rsp_fired_task,
   output logic              rsp_periodic,
   output logic              rsp_last
);

   cmd_type    cmd;
   status_type status;

   tds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tds_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_task_index  (req_task_index),
      .req_amount      (req_amount),
      .req_now         (req_now),
      .req_startup_add (req_startup_add),
      .cmd             (cmd),
      .status          (status),
      .rsp_fired       (rsp_fired),
      .rsp_fired_task  (rsp_fired_task),
      .rsp_periodic    (rsp_periodic),
      .rsp_last        (rsp_last)
   );

endmodule

[verif/task_deadline_scheduler_tb.sv]
module task_deadline_scheduler_tb;
   import tds_pkg::*;

   typedef struct {
      req_code_type kind;
      logic [3:0]   slot;
      logic [31:0]  amount;
      logic [31:0]  now;
      logic         startup;
   } request_type;

   typedef struct packed {
      logic       fired;
      logic [3:0] slot;
      logic       periodic;
      logic       last;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_ADD_ONCE;
   logic [3:0]  req_task_index = '0;
   logic [31:0] req_amount = '0;
   logic [31:0] req_now = '0;
   logic        req_startup_add = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_fired;
   logic [3:0]  rsp_fired_task;
   logic        rsp_periodic;
   logic        rsp_last;

   request_type request_queue[$];
   report_type  due_reports[$];
   logic [31:0] due_at[TASKS];
   logic [31:0] period_of[TASKS];
   logic [23:0] stagger;
   int          requests_taken = 0;
   int          request_total = 1000000;
   int          mismatches = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   wire         pace_on = (requests_taken % 90 < 60) && (requests_taken + 40 < request_total);

   task_deadline_scheduler uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_task_index(req_task_index),
      .req_amount(req_amount),
      .req_now(req_now),
      .req_startup_add(req_startup_add),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fired(rsp_fired),
      .rsp_fired_task(rsp_fired_task),
      .rsp_periodic(rsp_periodic),
      .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   // distance of a task that is behind, after whole periods are added
   function automatic logic [31:0] catch_up_distance(input logic [31:0] delta,
                                                     input logic [31:0] per);
      longint unsigned d64;
      longint unsigned p64;
      longint unsigned steps;
      d64 = delta;
      p64 = per;
      if (per[31] == 1'b0) begin
         steps = (64'h1_0000_0000 - d64 + p64 - 1) / p64;
      end else begin
         steps = (d64 - 64'h8000_0000) / (64'h1_0000_0000 - p64) + 1;
      end
      return 32'(d64 + steps * p64);
   endfunction

   task automatic schedule_update(input req_code_type kind, input logic [3:0] slot,
                                  input logic [31:0] amount, input logic [31:0] now,
                                  input logic startup);
      logic [31:0] delta;
      logic [31:0] next_due;
      if (kind == REQ_TICK) begin
         for (int s = 0; s < TASKS; s++) begin
            delta = due_at[s] - now;
            if (due_at[s] != 0 && (delta[31] || delta == 0)) begin
               if (period_of[s] != 0) begin
                  if (delta[31])
                     delta = catch_up_distance(delta, period_of[s]);
                  due_at[s] = now + delta;
               end else begin
                  due_at[s] = '0;
               end
               due_reports.push_back({1'b1, 4'(s), period_of[s] != 0, 1'b0});
            end
         end
         due_reports.push_back({1'b0, 4'd0, 1'b0, 1'b1});
      end else if (slot < TASKS) begin
         if (kind == REQ_REMOVE) begin
            due_at[slot] = '0;
            period_of[slot] = '0;
         end else begin
            next_due = now + amount;
            if (startup) begin
               next_due = next_due + {8'd0, stagger};
               stagger = stagger + STAGGER_STEP;
            end
            if (next_due == due_at[slot])
               next_due = next_due + 1;
            if (next_due == 0)
               next_due = 32'd1;
            due_at[slot] = next_due;
            period_of[slot] = (kind == REQ_ADD_REPEAT) ? amount : 32'd0;
         end
      end
   endtask

   task automatic add_request(input req_code_type kind, input logic [3:0] slot,
                              input logic [31:0] amount, input logic [31:0] now,
                              input logic startup);
      request_type item;
      item.kind = kind;
      item.slot = slot;
      item.amount = amount;
      item.now = now;
      item.startup = startup;
      request_queue.push_back(item);
   endtask

   always @(posedge clock) begin : drive_requests
      request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            schedule_update(req_code_type'(req_type), req_task_index, req_amount, req_now,
                            req_startup_add);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               item = request_queue.pop_front();
               req_valid <= 1'b1;
               req_type <= item.kind;
               req_task_index <= item.slot;
               req_amount <= item.amount;
               req_now <= item.now;
               req_startup_add <= item.startup;
               if (pace_on && $urandom_range(0, 4) == 0)
                  send_gap = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_reports
      report_type got;
      report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_fired, rsp_fired_task, rsp_periodic, rsp_last};
            if (due_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: fired=%0d task=%0d periodic=%0d last=%0d",
                           got.fired, got.slot, got.periodic, got.last);
            end else begin
               want = due_reports.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: fired %0d/%0d task %0d/%0d periodic %0d/%0d last %0d/%0d",
                              want.fired, got.fired, want.slot, got.slot,
                              want.periodic, got.periodic, want.last, got.last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pace_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #3000000;
      $display("[task_deadline_scheduler] ERROR");
      $finish;
   end

   initial begin
      logic [31:0] clk_now;
      logic [31:0] amt;
      int pick;
      int sel;
      for (int s = 0; s < TASKS; s++) begin
         due_at[s] = '0;
         period_of[s] = '0;
      end
      stagger = '0;

      // directed: empty table, bumps, zero fix-up, wrap, catch-up, landing on zero
      add_request(REQ_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
      add_request(REQ_ADD_ONCE, 4'd0, 32'd0, 32'd0, 1'b0);
      add_request(REQ_ADD_ONCE, 4'd1, 32'hFFFF_FFFF, 32'd1, 1'b0);
      add_request(REQ_ADD_ONCE, 4'd1, 32'd0, 32'd1, 1'b0);
      add_request(REQ_ADD_REPEAT, 4'd2, 32'd100, 32'hFFFF_FFF0, 1'b1);
      add_request(REQ_ADD_REPEAT, 4'd3, 32'h9000_0000, 32'h10, 1'b1);
      add_request(REQ_ADD_REPEAT, 4'd4, 32'd0, 32'd5, 1'b0);
      add_request(REQ_ADD_REPEAT, 4'd6, 32'd16, 32'hFFFF_FFE0, 1'b0);
      add_request(REQ_ADD_ONCE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_request(REQ_TICK, 4'd15, 32'hFFFF_FFFF, 32'd0, 1'b1);
      add_request(REQ_TICK, 4'd0, 32'd0, 32'd5, 1'b0);
      add_request(REQ_REMOVE, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_request(REQ_ADD_REPEAT, 4'd5, 32'd10, 32'd0, 1'b0);
      add_request(REQ_TICK, 4'd0, 32'd0, 32'h7FFF_FFF0, 1'b0);
      add_request(REQ_ADD_REPEAT, 4'd7, 32'hFFFF_FFFF, 32'd0, 1'b0);
      add_request(REQ_TICK, 4'd0, 32'd0, 32'h8000_0000, 1'b0);
      add_request(REQ_TICK, 4'd9, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
      add_request(REQ_ADD_ONCE, 4'd8, 32'h7FFF_FFFF, 32'd0, 1'b1);
      add_request(REQ_ADD_ONCE, 4'd9, 32'h8000_0000, 32'd0, 1'b0);
      add_request(REQ_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
      add_request(REQ_REMOVE, 4'd15, 32'd0, 32'd0, 1'b0);
      add_request(REQ_ADD_REPEAT, 4'd10, 32'h8000_0001, 32'h4000_0000, 1'b0);
      add_request(REQ_TICK, 4'd0, 32'd0, 32'hF000_0000, 1'b0);
      add_request(REQ_TICK, 4'd3, 32'd0, 32'hFFFF_FFFF, 1'b0);

      clk_now = $urandom;
      while (request_queue.size() < 430) begin
         pick = $urandom_range(0, 99);
         sel = $urandom_range(0, 9);
         if (pick < 8) begin
            add_request(req_code_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                        $urandom, $urandom, 1'($urandom_range(0, 1)));
         end else if (pick < 43) begin
            if (sel < 6)
               amt = $urandom_range(1, 3000);
            else if (sel < 8)
               amt = $urandom_range(0, 20);
            else if (sel == 8)
               amt = $urandom;
            else
               amt = 32'h8000_0000 + $urandom_range(0, 4000);
            add_request(req_code_type'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                        amt, clk_now, $urandom_range(0, 5) == 0);
         end else if (pick < 50) begin
            add_request(REQ_REMOVE, 4'($urandom_range(0, 15)), $urandom, $urandom,
                        1'($urandom_range(0, 1)));
         end else begin
            if (sel < 7)
               clk_now = clk_now + $urandom_range(0, 800);
            else if (sel == 7)
               clk_now = clk_now + $urandom_range(0, 32'h00FF_FFFF);
            else if (sel == 8)
               clk_now = clk_now + $urandom_range(0, 32'h7FFF_FFFF);
            add_request(REQ_TICK, 4'($urandom_range(0, 15)), $urandom, clk_now,
                        1'($urandom_range(0, 1)));
         end
      end
      request_total = request_queue.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < request_total || due_reports.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("[task_deadline_scheduler] OK");
      end else begin
         $display("[task_deadline_scheduler] ERROR");
      end
      $finish;
   end

endmodule
